[rtl/lpbm_pkg.sv]
`default_nettype none
package lpbm_pkg;

   // field widths
   localparam int unsigned CfgW   = 8;
   localparam int unsigned CountW = 9;
   localparam int unsigned IdxW   = 3;

   // result command codes
   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_OFFLINE = 2'd1,
      CMD_ONLINE  = 2'd2
   } cmd_type;

   // configuration register indexes
   typedef enum logic [IdxW-1:0] {
      REG_OFFLINE_MIN_INTERVAL = 3'd0,
      REG_DOUBLING_PERIOD      = 3'd1,
      REG_OFFLINE_MAX_INTERVAL = 3'd2,
      REG_ONLINE_INTERVAL      = 3'd3,
      REG_RETRY_INTERVAL       = 3'd4,
      REG_ERRORS_TO_OFFLINE    = 3'd5
   } reg_idx_type;

   // register reset values
   localparam logic [CfgW-1:0] RST_OFFLINE_MIN = 8'd1;
   localparam logic [CfgW-1:0] RST_DOUBLING    = 8'd60;
   localparam logic [CfgW-1:0] RST_OFFLINE_MAX = 8'd64;
   localparam logic [CfgW-1:0] RST_ONLINE      = 8'd60;
   localparam logic [CfgW-1:0] RST_RETRY       = 8'd1;
   localparam logic [CfgW-1:0] RST_ERRORS      = 8'd5;

   localparam logic [CfgW-1:0] TALLY_MAX = 8'd255;

endpackage
`default_nettype wire

[rtl/link_probe_backoff_monitor_unit.sv]
// Link probe monitor with exponential offline backoff.
// req_ channel: one beat per tick, carrying the reported link state
// (req_reported_online) and the probe result (req_probe_ok). A beat is taken
// when req_valid is high and req_stall is low.
// rsp_ channel: exactly one beat per request beat, in order: probe_used,
// command (none / go offline / go online), failure_count and ticks_to_probe.
// csr_ channel: register index and 8-bit data; csr_ready is always high, and
// writes to indexes past the last register are dropped. Write only while idle.
// A request beat lands in the input register, then the state update and result
// are computed combinationally into the output register. One beat per cycle is
// sustained while rsp_stall is low; the countdown/backoff update is a single
// short add-and-compare path.
// Reset (synchronous, active high) loads the register defaults, clears the
// error count and the probe countdown (so the first tick probes), and empties
// both pipeline registers. When rsp_stall is high the output register holds
// its beat; the input register still takes one more beat, then req_stall rises.
`default_nettype none
module link_probe_backoff_monitor_unit
   import lpbm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_reported_online,
   input  wire logic               req_probe_ok,
   // response channel
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic               rsp_probe_used,
   output      logic [1:0]         rsp_command,
   output      logic [CfgW-1:0]    rsp_failure_count,
   output      logic [CountW-1:0]  rsp_ticks_to_probe,
   // configuration channel
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [IdxW-1:0]    csr_index,
   input  wire logic [CfgW-1:0]    csr_data
);

   // configuration registers
   logic [CfgW-1:0] off_min_ff, dbl_period_ff, off_max_ff;
   logic [CfgW-1:0] online_ivl_ff, retry_ivl_ff, err_limit_ff;

   // input register
   logic in_valid_ff, in_online_ff, in_ok_ff;

   // monitor state
   logic [CountW-1:0] countdown_ff, countdown_in;
   logic [CountW-1:0] interval_ff, interval_in;
   logic [CfgW-1:0]   dbl_cnt_ff, dbl_cnt_in;
   logic [CfgW-1:0]   tally_ff, tally_in;

   // output register
   logic              out_valid_ff;
   logic              out_used_ff, out_used_in;
   cmd_type           out_cmd_ff, out_cmd_in;
   logic [CfgW-1:0]   out_tally_ff;
   logic [CountW-1:0] out_ticks_ff, out_ticks_in;

   logic              advance;
   logic [CfgW-1:0]   dbl_dec;
   logic [CfgW-1:0]   tally_inc;
   logic [CountW-1:0] wait_ticks;

   // handshake
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         off_min_ff    <= RST_OFFLINE_MIN;
         dbl_period_ff <= RST_DOUBLING;
         off_max_ff    <= RST_OFFLINE_MAX;
         online_ivl_ff <= RST_ONLINE;
         retry_ivl_ff  <= RST_RETRY;
         err_limit_ff  <= RST_ERRORS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_OFFLINE_MIN_INTERVAL: off_min_ff    <= csr_data;
            REG_DOUBLING_PERIOD:      dbl_period_ff <= csr_data;
            REG_OFFLINE_MAX_INTERVAL: off_max_ff    <= csr_data;
            REG_ONLINE_INTERVAL:      online_ivl_ff <= csr_data;
            REG_RETRY_INTERVAL:       retry_ivl_ff  <= csr_data;
            REG_ERRORS_TO_OFFLINE:    err_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_online_ff <= req_reported_online;
         in_ok_ff     <= req_probe_ok;
      end
   end

   // per-tick update: backoff doubling, then probe decision, then countdown
   always_comb begin
      dbl_dec      = dbl_cnt_ff - 1'b1;
      tally_inc    = (tally_ff != TALLY_MAX) ? tally_ff + 1'b1 : tally_ff;
      interval_in  = interval_ff;
      dbl_cnt_in   = dbl_cnt_ff;
      tally_in     = tally_ff;
      wait_ticks   = countdown_ff;
      out_used_in  = 1'b0;
      out_cmd_in   = CMD_NONE;

      // offline backoff
      if (!in_online_ff && (interval_ff < {1'b0, off_max_ff})) begin
         dbl_cnt_in = dbl_dec;
         if (dbl_dec == '0) begin
            interval_in = {interval_ff[CountW-2:0], 1'b0};
            dbl_cnt_in  = dbl_period_ff;
         end
      end

      // probe due
      if (countdown_ff == '0) begin
         out_used_in = 1'b1;
         if (!in_ok_ff) begin
            if (in_online_ff) begin
               tally_in = tally_inc;
               if (tally_inc >= err_limit_ff) begin
                  out_cmd_in  = CMD_OFFLINE;
                  interval_in = {1'b0, off_min_ff};
                  wait_ticks  = {1'b0, off_min_ff};
                  dbl_cnt_in  = dbl_period_ff;
               end else begin
                  wait_ticks = {1'b0, retry_ivl_ff};
               end
            end else begin
               wait_ticks = interval_in;
            end
         end else begin
            if (!in_online_ff) out_cmd_in = CMD_ONLINE;
            tally_in   = '0;
            wait_ticks = {1'b0, online_ivl_ff};
         end
      end

      // countdown never goes below zero
      countdown_in = (wait_ticks != '0) ? wait_ticks - 1'b1 : wait_ticks;
      out_ticks_in = countdown_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         interval_ff  <= {1'b0, RST_OFFLINE_MIN};
         dbl_cnt_ff   <= RST_DOUBLING;
         tally_ff     <= '0;
      end else if (advance) begin
         countdown_ff <= countdown_in;
         interval_ff  <= interval_in;
         dbl_cnt_ff   <= dbl_cnt_in;
         tally_ff     <= tally_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_used_ff  <= out_used_in;
         out_cmd_ff   <= out_cmd_in;
         out_tally_ff <= tally_in;
         out_ticks_ff <= out_ticks_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_probe_used     = out_used_ff;
   assign rsp_command        = out_cmd_ff;
   assign rsp_failure_count  = out_tally_ff;
   assign rsp_ticks_to_probe = out_ticks_ff;

endmodule
`default_nettype wire

[rtl/lpbm_checker.sv]
`default_nettype none
module lpbm_checker
   import lpbm_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_probe_used,
   input wire logic [1:0]         rsp_command,
   input wire logic [CfgW-1:0]    rsp_failure_count,
   input wire logic [CountW-1:0]  rsp_ticks_to_probe
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_probe_used)
         && $stable(rsp_command) && $stable(rsp_failure_count)
         && $stable(rsp_ticks_to_probe))
      else $error("response beat changed while stalled");

   // commands only come from a probe
   a_cmd_needs_probe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_probe_used |-> rsp_command == CMD_NONE)
      else $error("command without probe");

   // going online means the probe passed, so errors are cleared
   a_online_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_ONLINE |-> rsp_failure_count == '0)
      else $error("online command with errors left");

   // going offline follows at least one counted failure
   a_offline_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_OFFLINE |-> rsp_failure_count != '0)
      else $error("offline command with no errors");

endmodule

bind link_probe_backoff_monitor_unit lpbm_checker u_lpbm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_probe_used     (rsp_probe_used),
   .rsp_command        (rsp_command),
   .rsp_failure_count  (rsp_failure_count),
   .rsp_ticks_to_probe (rsp_ticks_to_probe)
);
`default_nettype wire

[tb/link_probe_backoff_monitor_unit_tb.sv]
`default_nettype none
module link_probe_backoff_monitor_unit_tb;
   import lpbm_pkg::*;

   localparam int unsigned HALF_PERIOD    = 6;
   localparam int unsigned TIMEOUT_CYCLES = 400000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned NUM_PHASES     = 10;

   // indexes past the last register, writes there are dropped
   localparam logic [IdxW-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [IdxW-1:0] REG_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic              used;
      cmd_type           cmd;
      logic [CfgW-1:0]   count;
      logic [CountW-1:0] ticks;
   } tick_result_type;

   typedef struct {
      logic              is_cfg;
      logic              online;
      logic              ok;
      logic [IdxW-1:0]   idx;
      logic [CfgW-1:0]   data;
      logic              has_exp;
      tick_result_type   exp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid           = 1'b0;
   logic              req_stall;
   logic              req_reported_online = 1'b0;
   logic              req_probe_ok        = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall           = 1'b0;
   logic              rsp_probe_used;
   logic [1:0]        rsp_command;
   logic [CfgW-1:0]   rsp_failure_count;
   logic [CountW-1:0] rsp_ticks_to_probe;
   logic              csr_valid           = 1'b0;
   logic              csr_ready;
   logic [IdxW-1:0]   csr_index           = '0;
   logic [CfgW-1:0]   csr_data            = '0;

   // predictor copy of the registers
   logic [CfgW-1:0] cfg_min_interval = RST_OFFLINE_MIN;
   logic [CfgW-1:0] cfg_dbl_period   = RST_DOUBLING;
   logic [CfgW-1:0] cfg_max_interval = RST_OFFLINE_MAX;
   logic [CfgW-1:0] cfg_online_wait  = RST_ONLINE;
   logic [CfgW-1:0] cfg_retry_wait   = RST_RETRY;
   logic [CfgW-1:0] cfg_err_limit    = RST_ERRORS;

   // predictor copy of the state
   logic [CountW-1:0] mon_countdown = '0;
   logic [CountW-1:0] mon_interval  = CountW'(RST_OFFLINE_MIN);
   logic [CfgW-1:0]   mon_dbl_count = RST_DOUBLING;
   logic [CfgW-1:0]   mon_tally     = '0;

   tick_result_type pending_results[$];
   dir_row_type     dir_rows[$];
   int unsigned     mismatch_count = 0;

   link_probe_backoff_monitor_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_reported_online(req_reported_online),
      .req_probe_ok       (req_probe_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_probe_used     (rsp_probe_used),
      .rsp_command        (rsp_command),
      .rsp_failure_count  (rsp_failure_count),
      .rsp_ticks_to_probe (rsp_ticks_to_probe),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // one tick of the monitor: backoff, then probe, then countdown
   task automatic predict_tick(input logic online, input logic ok,
                               output tick_result_type r);
      r.used = 1'b0;
      r.cmd  = CMD_NONE;
      if (!online && mon_interval < CountW'(cfg_max_interval)) begin
         mon_dbl_count = mon_dbl_count - 1'b1;
         if (mon_dbl_count == '0) begin
            mon_interval  = {mon_interval[CountW-2:0], 1'b0};
            mon_dbl_count = cfg_dbl_period;
         end
      end
      if (mon_countdown == '0) begin
         r.used = 1'b1;
         if (!ok) begin
            if (online) begin
               if (mon_tally != TALLY_MAX) mon_tally = mon_tally + 1'b1;
               if (mon_tally >= cfg_err_limit) begin
                  r.cmd         = CMD_OFFLINE;
                  mon_interval  = CountW'(cfg_min_interval);
                  mon_countdown = CountW'(cfg_min_interval);
                  mon_dbl_count = cfg_dbl_period;
               end else begin
                  mon_countdown = CountW'(cfg_retry_wait);
               end
            end else begin
               mon_countdown = mon_interval;
            end
         end else begin
            if (!online) r.cmd = CMD_ONLINE;
            mon_tally     = '0;
            mon_countdown = CountW'(cfg_online_wait);
         end
      end
      if (mon_countdown != '0) mon_countdown = mon_countdown - 1'b1;
      r.count = mon_tally;
      r.ticks = mon_countdown;
   endtask

   task automatic add_tick(input logic online, input logic ok);
      dir_row_type row;
      row = '{is_cfg: 1'b0, online: online, ok: ok, idx: '0, data: '0,
              has_exp: 1'b0, exp: '0};
      dir_rows.push_back(row);
   endtask

   task automatic add_tick_exp(input logic online, input logic ok, input logic used,
                               input cmd_type cmd, input logic [CfgW-1:0] count,
                               input logic [CountW-1:0] ticks);
      dir_row_type row;
      row = '{is_cfg: 1'b0, online: online, ok: ok, idx: '0, data: '0,
              has_exp: 1'b1, exp: '0};
      row.exp.used  = used;
      row.exp.cmd   = cmd;
      row.exp.count = count;
      row.exp.ticks = ticks;
      dir_rows.push_back(row);
   endtask

   task automatic add_cfg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
      dir_row_type row;
      row = '{is_cfg: 1'b1, online: 1'b0, ok: 1'b0, idx: idx, data: data,
              has_exp: 1'b0, exp: '0};
      dir_rows.push_back(row);
   endtask

   // one beat on the request channel; valid stays high for a following beat
   task automatic send_tick(input logic online, input logic ok,
                            input logic has_exp, input tick_result_type exp);
      tick_result_type r;
      req_valid           <= 1'b1;
      req_reported_online <= online;
      req_probe_ok        <= ok;
      do @(posedge clock); while (req_stall);
      predict_tick(online, ok, r);
      pending_results.push_back(has_exp ? exp : r);
   endtask

   // register write; caller lowers csr_valid after the last one
   task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_OFFLINE_MIN_INTERVAL: cfg_min_interval = data;
         REG_DOUBLING_PERIOD:      cfg_dbl_period   = data;
         REG_OFFLINE_MAX_INTERVAL: cfg_max_interval = data;
         REG_ONLINE_INTERVAL:      cfg_online_wait  = data;
         REG_RETRY_INTERVAL:       cfg_retry_wait   = data;
         REG_ERRORS_TO_OFFLINE:    cfg_err_limit    = data;
         default: ;
      endcase
   endtask

   // stop sending and let every outstanding beat drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register values lean on the extremes and on small intervals
   function automatic logic [CfgW-1:0] pick_cfg_value();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd255;
         3, 4:    return CfgW'($urandom_range(2, 255));
         default: return CfgW'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic check_field(input string name, input logic [CountW-1:0] want,
                              input logic [CountW-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // receiver: stall mode (none, light or heavy) is redrawn when stall_left runs out
   logic [1:0] stall_mode = '0;
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         stall_mode <= '0;
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 2));
            stall_left <= $urandom_range(20, 120);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            2'd0:    rsp_stall <= 1'b0;
            2'd1:    rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response beat, actual used %0d cmd %0d count %0d ticks %0d",
                     $time, rsp_probe_used, rsp_command, rsp_failure_count,
                     rsp_ticks_to_probe);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("probe_used", CountW'(want.used), CountW'(rsp_probe_used));
            check_field("command", CountW'(want.cmd), CountW'(rsp_command));
            check_field("failure_count", CountW'(want.count), CountW'(rsp_failure_count));
            check_field("ticks_to_probe", want.ticks, rsp_ticks_to_probe);
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("FAIL link_probe_backoff_monitor_unit");
      $finish;
   end

   initial begin
      logic            in_cfg;
      logic            online;
      logic            ok;
      int unsigned     burst_left;
      int unsigned     run_left;
      int unsigned     ok_pct;
      int unsigned     num_items;
      logic [CfgW-1:0] value;
      tick_result_type no_exp;

      in_cfg     = 1'b0;
      burst_left = 0;
      no_exp     = '0;

      // defaults: online failures count up to the offline command
      add_tick_exp(1'b1, 1'b0, 1'b1, CMD_NONE, 8'd1, 9'd0);
      add_tick_exp(1'b1, 1'b0, 1'b1, CMD_NONE, 8'd2, 9'd0);
      add_tick_exp(1'b1, 1'b0, 1'b1, CMD_NONE, 8'd3, 9'd0);
      add_tick_exp(1'b1, 1'b0, 1'b1, CMD_NONE, 8'd4, 9'd0);
      add_tick_exp(1'b1, 1'b0, 1'b1, CMD_OFFLINE, 8'd5, 9'd0);
      // offline failure keeps the error count
      add_tick_exp(1'b0, 1'b0, 1'b1, CMD_NONE, 8'd5, 9'd0);
      // zero waits and zero error threshold
      add_cfg(REG_ONLINE_INTERVAL, 8'd0);
      add_cfg(REG_RETRY_INTERVAL, 8'd0);
      add_cfg(REG_ERRORS_TO_OFFLINE, 8'd0);
      add_tick_exp(1'b0, 1'b1, 1'b1, CMD_ONLINE, 8'd0, 9'd0);
      add_tick_exp(1'b1, 1'b0, 1'b1, CMD_OFFLINE, 8'd1, 9'd0);
      // dropped writes, then doubling every offline tick up to 256, past the 255 maximum
      add_cfg(REG_UNUSED_6, 8'hFF);
      add_cfg(REG_UNUSED_7, 8'h00);
      add_cfg(REG_DOUBLING_PERIOD, 8'd1);
      add_cfg(REG_OFFLINE_MAX_INTERVAL, 8'd255);
      add_cfg(REG_ERRORS_TO_OFFLINE, 8'd1);
      add_tick_exp(1'b1, 1'b0, 1'b1, CMD_OFFLINE, 8'd2, 9'd0);
      add_tick_exp(1'b0, 1'b0, 1'b1, CMD_NONE, 8'd2, 9'd1);
      add_tick_exp(1'b0, 1'b0, 1'b0, CMD_NONE, 8'd2, 9'd0);
      add_tick_exp(1'b0, 1'b0, 1'b1, CMD_NONE, 8'd2, 9'd7);
      add_tick(1'b0, 1'b1);
      add_tick(1'b0, 1'b1);
      add_tick(1'b0, 1'b1);
      add_tick(1'b0, 1'b1);
      add_tick(1'b0, 1'b0);
      add_tick(1'b0, 1'b1);
      add_tick(1'b0, 1'b0);
      add_tick_exp(1'b0, 1'b1, 1'b1, CMD_ONLINE, 8'd0, 9'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            if (!in_cfg) begin
               wait_idle();
               in_cfg = 1'b1;
            end
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            if (in_cfg) begin
               csr_valid <= 1'b0;
               in_cfg = 1'b0;
            end
            send_tick(dir_rows[i].online, dir_rows[i].ok, dir_rows[i].has_exp,
                      dir_rows[i].exp);
         end
      end

      // random phases; the first one drives the error count into saturation
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         for (int r = 0; r < 6; r++) begin
            value = pick_cfg_value();
            if (ph == 0) begin
               case (r)
                  REG_OFFLINE_MIN_INTERVAL: value = 8'd1;
                  REG_RETRY_INTERVAL:       value = 8'd0;
                  REG_ERRORS_TO_OFFLINE:    value = 8'd255;
                  default: ;
               endcase
            end
            write_reg(IdxW'(r), value);
         end
         if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, CfgW'($urandom));
         csr_valid <= 1'b0;

         num_items = (ph == 0) ? 300 : 60;
         ok_pct    = (ph == 0) ? 0 : $urandom_range(0, 100);
         online    = 1'($urandom);
         run_left  = 0;
         for (int n = 0; n < num_items; n++) begin
            // link state comes in runs of random length
            if (run_left == 0) begin
               online   = (ph == 0) ? 1'b1 : ~online;
               run_left = $urandom_range(1, 40);
            end
            run_left--;
            ok = ($urandom_range(0, 99) < ok_pct);
            // sender bursts with gaps between them
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 2) != 0) begin
                  req_valid <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
            end
            burst_left--;
            send_tick(online, ok, 1'b0, no_exp);
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS link_probe_backoff_monitor_unit");
      else
         $display("FAIL link_probe_backoff_monitor_unit");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
rtl/lpbm_pkg.sv
rtl/link_probe_backoff_monitor_unit.sv
rtl/lpbm_checker.sv
tb/link_probe_backoff_monitor_unit_tb.sv
